[design/rmq_pkg.sv]
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: shared package
// Widths, pipeline depths, the branch code, the request record passed between
// the front end, the queue and the back end, and the back end's stage records.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int FRAC_BITS   = 14;
  localparam int DATA_W      = 16;
  localparam int NUM_W       = 17;
  localparam int RAD_W       = 32;
  localparam int ROOT_W      = 16;
  localparam int QUO_W       = 24;
  localparam int SQRT_STAGES = 16;
  localparam int DIV_STAGES  = 24;

  typedef enum logic [1:0] {
    MODE_TRACE,
    MODE_X,
    MODE_Y,
    MODE_Z
  } mode_t;

  typedef struct packed {
    mode_t                    mode;
    logic                     deg;
    logic signed [NUM_W-1:0]  n0;
    logic signed [NUM_W-1:0]  n1;
    logic signed [NUM_W-1:0]  n2;
    logic [RAD_W-1:0]         rad;
  } item_t;

  typedef struct packed {
    item_t             item;
    logic [RAD_W-1:0]  rem;
    logic [RAD_W-1:0]  root;
  } sq_stage_t;

  typedef struct packed {
    logic               valid;
    mode_t              mode;
    logic               deg;
    logic [ROOT_W-1:0]  half;
  } ctrl_t;

endpackage

[design/rmq_if.sv]
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: channel interfaces
// Matrix request channel and quaternion result channel, valid/ready.
// ----------------------------------------------------------------------------
interface rmq_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] r00;
  logic signed [15:0] r01;
  logic signed [15:0] r02;
  logic signed [15:0] r10;
  logic signed [15:0] r11;
  logic signed [15:0] r12;
  logic signed [15:0] r20;
  logic signed [15:0] r21;
  logic signed [15:0] r22;

  modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  input ready);
  modport sink (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                output ready);
endinterface

interface rmq_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic               degenerate;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, degenerate,
                  input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, degenerate,
                output ready);
endinterface

[design/rotation_matrix_to_quaternion_top.sv]
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: top level
// Shepperd conversion of a Q2.14 rotation matrix to a unit quaternion.
//
//   Channel  Direction  Carries
//   in       sink       r00 .. r22, one matrix per request
//   out      source     quat_w, quat_x, quat_y, quat_z, degenerate
//
// One request is accepted per cycle while the queue has room. Its result passes
// the front end register, a queue entry, the 16-stage square root pipeline, the
// operand register, the 24-stage divider pipeline and the output register.
// Reset clears only the valid flags and the queue pointers and count; there is no clearing pass.
// A stall on the output freezes the back pipeline; the two-entry queue lets
// the front end keep accepting until it fills.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_top (
  input  logic       clk,
  input  logic       rst,
  rmq_in_if.sink     in,
  rmq_out_if.source  out
);
  import rmq_pkg::*;

  logic  f_valid;
  logic  f_ready;
  item_t f_item;
  logic  b_valid;
  logic  b_ready;
  item_t b_item;

  rmq_front u_front (
    .clk   (clk),
    .rst   (rst),
    .in    (in),
    .valid (f_valid),
    .ready (f_ready),
    .item  (f_item)
  );

  rmq_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_item   (b_item)
  );

  rmq_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (b_valid),
    .in_ready (b_ready),
    .in_item  (b_item),
    .out      (out)
  );

endmodule

[design/rmq_front.sv]
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: front end
// Picks the trace or the dominant diagonal axis, forms the radicand and the
// three numerators, and registers the classified request.
// ----------------------------------------------------------------------------
module rmq_front (
  input  logic           clk,
  input  logic           rst,
  rmq_in_if.sink         in,
  output logic           valid,
  input  logic           ready,
  output rmq_pkg::item_t item
);
  import rmq_pkg::*;

  logic signed [DATA_W-1:0] m [3][3];
  logic signed [17:0]       tr;
  logic signed [17:0]       rad;
  logic [1:0]               ii;
  logic [1:0]               jj;
  logic [1:0]               kk;
  item_t                    item_next;
  logic                     take;

  function automatic logic signed [17:0] sx18(input logic signed [DATA_W-1:0] a);
    return {{2{a[DATA_W-1]}}, a};
  endfunction

  function automatic logic signed [NUM_W-1:0] sx17(input logic signed [DATA_W-1:0] a);
    return {a[DATA_W-1], a};
  endfunction

  assign m[0][0] = in.r00;
  assign m[0][1] = in.r01;
  assign m[0][2] = in.r02;
  assign m[1][0] = in.r10;
  assign m[1][1] = in.r11;
  assign m[1][2] = in.r12;
  assign m[2][0] = in.r20;
  assign m[2][1] = in.r21;
  assign m[2][2] = in.r22;

  always_comb begin
    tr = sx18(in.r00) + sx18(in.r11) + sx18(in.r22);
    ii = 2'd0;
    if (in.r11 > in.r00) begin
      ii = 2'd1;
    end
    if (in.r22 > m[ii][ii]) begin
      ii = 2'd2;
    end
    case (ii)
      2'd0: begin
        jj = 2'd1;
        kk = 2'd2;
      end
      2'd1: begin
        jj = 2'd2;
        kk = 2'd0;
      end
      default: begin
        jj = 2'd0;
        kk = 2'd1;
      end
    endcase

    if (tr > 18'sd0) begin
      rad          = tr + 18'sd16384;
      item_next.mode = MODE_TRACE;
      item_next.n0 = sx17(in.r12) - sx17(in.r21);
      item_next.n1 = sx17(in.r20) - sx17(in.r02);
      item_next.n2 = sx17(in.r01) - sx17(in.r10);
    end else begin
      rad = 18'sd16384 + sx18(m[ii][ii]) - sx18(m[jj][jj]) - sx18(m[kk][kk]);
      case (ii)
        2'd0:    item_next.mode = MODE_X;
        2'd1:    item_next.mode = MODE_Y;
        default: item_next.mode = MODE_Z;
      endcase
      item_next.n0 = sx17(m[jj][kk]) - sx17(m[kk][jj]);
      item_next.n1 = sx17(m[ii][jj]) + sx17(m[jj][ii]);
      item_next.n2 = sx17(m[ii][kk]) + sx17(m[kk][ii]);
    end

    item_next.deg = (rad <= 18'sd0);
    if (item_next.deg) begin
      item_next.rad = RAD_W'(32'h0000_4000);
    end else begin
      item_next.rad = RAD_W'({rad[16:0], {FRAC_BITS{1'b0}}});
    end
  end

  assign in.ready = !valid || ready;
  assign take     = in.valid && in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in.ready) begin
      valid <= in.valid;
    end
    if (take) begin
      item <= item_next;
    end
  end

endmodule

[design/rmq_queue.sv]
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: request queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module rmq_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  rmq_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output rmq_pkg::item_t pop_item
);
  import rmq_pkg::*;

  item_t       mem [2];
  logic        wp;
  logic        rp;
  logic [1:0]  count;
  logic        push;
  logic        pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_item   = mem[rp];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wp <= !wp;
      end
      if (pop) begin
        rp <= !rp;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
    if (push) begin
      mem[wp] <= push_item;
    end
  end

endmodule

[design/rmq_sqrt.sv]
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: square root pipeline
// Integer square root of the radicand, one result bit per stage, with the
// request record carried alongside.
// ----------------------------------------------------------------------------
module rmq_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        v_in,
  input  rmq_pkg::item_t              d_in,
  output logic                        v_out,
  output rmq_pkg::item_t              d_out,
  output logic [rmq_pkg::ROOT_W-1:0]  root
);
  import rmq_pkg::*;

  sq_stage_t st [SQRT_STAGES+1];
  logic      vs [SQRT_STAGES+1];

  assign st[0].item = d_in;
  assign st[0].rem  = d_in.rad;
  assign st[0].root = '0;
  assign vs[0]      = v_in;

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
    localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (RAD_W - 2 - 2 * s);
    logic [RAD_W-1:0] trial;
    sq_stage_t        nxt;

    always_comb begin
      trial    = st[s].root + BIT;
      nxt.item = st[s].item;
      if (st[s].rem >= trial) begin
        nxt.rem  = st[s].rem - trial;
        nxt.root = (st[s].root >> 1) + BIT;
      end else begin
        nxt.rem  = st[s].rem;
        nxt.root = st[s].root >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[s+1] <= 1'b0;
      end else if (en) begin
        vs[s+1] <= vs[s];
      end
      if (en) begin
        st[s+1] <= nxt;
      end
    end
  end

  assign v_out = vs[SQRT_STAGES];
  assign d_out = st[SQRT_STAGES].item;
  assign root  = st[SQRT_STAGES].root[ROOT_W-1:0];

endmodule

[design/rmq_div.sv]
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: divider pipeline
// Restoring division of a magnitude by twice the root, one quotient bit per
// stage; the sign travels with the operands.
// ----------------------------------------------------------------------------
module rmq_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [rmq_pkg::RAD_W-1:0]  dividend,
  input  logic [rmq_pkg::NUM_W-1:0]  divisor,
  input  logic                       neg_in,
  output logic [rmq_pkg::QUO_W-1:0]  quo,
  output logic                       neg_out
);
  import rmq_pkg::*;

  logic [NUM_W-1:0] rem [DIV_STAGES+1];
  logic [QUO_W-1:0] low [DIV_STAGES+1];
  logic [QUO_W-1:0] qs  [DIV_STAGES+1];
  logic [NUM_W-1:0] dv  [DIV_STAGES+1];
  logic             ng  [DIV_STAGES+1];

  assign rem[0] = NUM_W'(dividend[RAD_W-1:QUO_W]);
  assign low[0] = dividend[QUO_W-1:0];
  assign qs[0]  = '0;
  assign dv[0]  = divisor;
  assign ng[0]  = neg_in;

  for (genvar t = 0; t < DIV_STAGES; t++) begin : g_stage
    logic [NUM_W:0]   sh;
    logic             qbit;
    logic [NUM_W-1:0] rem_next;

    always_comb begin
      sh   = {rem[t], low[t][QUO_W-1]};
      qbit = (sh >= {1'b0, dv[t]});
      if (qbit) begin
        rem_next = NUM_W'(sh - {1'b0, dv[t]});
      end else begin
        rem_next = sh[NUM_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[t+1] <= rem_next;
        low[t+1] <= {low[t][QUO_W-2:0], 1'b0};
        qs[t+1]  <= {qs[t][QUO_W-2:0], qbit};
        dv[t+1]  <= dv[t];
        ng[t+1]  <= ng[t];
      end
    end
  end

  assign quo     = qs[DIV_STAGES];
  assign neg_out = ng[DIV_STAGES];

endmodule

[design/rmq_back.sv]
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: back end
// Square root, operand setup, three dividers, then sign, saturation and
// placement of the components in the output register, or zeros when degenerate.
// ----------------------------------------------------------------------------
module rmq_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rmq_pkg::item_t in_item,
  rmq_out_if.source      out
);
  import rmq_pkg::*;

  logic              adv;
  logic              sq_v;
  item_t             sq_item;
  logic [ROOT_W-1:0] h;
  logic [RAD_W-1:0]  dvd [3];
  logic [NUM_W-1:0]  dvs;
  logic              ngs [3];
  logic [QUO_W-1:0]  q   [3];
  logic              qn  [3];
  logic [RAD_W-1:0]  p_dvd [3];
  logic [NUM_W-1:0]  p_dvs;
  logic              p_ng  [3];
  ctrl_t             p_ctrl;
  ctrl_t             ctrl [DIV_STAGES+1];
  logic signed [15:0] c [3];

  function automatic logic signed [15:0] sat(input logic [QUO_W-1:0] v, input logic n);
    if (!n) begin
      return (v > QUO_W'(32767)) ? 16'sh7fff : $signed(v[15:0]);
    end
    return (v >= QUO_W'(32768)) ? 16'sh8000 : $signed(16'(-v[15:0]));
  endfunction

  assign adv      = !out.valid || out.ready;
  assign in_ready = adv;

  rmq_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .en    (adv),
    .v_in  (in_valid),
    .d_in  (in_item),
    .v_out (sq_v),
    .d_out (sq_item),
    .root  (h)
  );

  always_comb begin
    logic [NUM_W-1:0] mag [3];
    logic signed [NUM_W-1:0] n [3];
    n[0] = sq_item.n0;
    n[1] = sq_item.n1;
    n[2] = sq_item.n2;
    for (int l = 0; l < 3; l++) begin
      ngs[l] = n[l][NUM_W-1];
      mag[l] = ngs[l] ? NUM_W'(-n[l]) : NUM_W'(n[l]);
      dvd[l] = RAD_W'({mag[l], {FRAC_BITS{1'b0}}}) + RAD_W'(h);
    end
    dvs = {h, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_ctrl.valid <= 1'b0;
    end else if (adv) begin
      p_ctrl.valid <= sq_v;
    end
    if (adv) begin
      p_ctrl.mode <= sq_item.mode;
      p_ctrl.deg  <= sq_item.deg;
      p_ctrl.half <= ROOT_W'((17'(h) + 17'd1) >> 1);
      p_dvd       <= dvd;
      p_dvs       <= dvs;
      p_ng        <= ngs;
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    rmq_div u_div (
      .clk      (clk),
      .en       (adv),
      .dividend (p_dvd[l]),
      .divisor  (p_dvs),
      .neg_in   (p_ng[l]),
      .quo      (q[l]),
      .neg_out  (qn[l])
    );
  end

  assign ctrl[0] = p_ctrl;

  for (genvar t = 0; t < DIV_STAGES; t++) begin : g_ctrl
    always_ff @(posedge clk) begin
      if (rst) begin
        ctrl[t+1].valid <= 1'b0;
      end else if (adv) begin
        ctrl[t+1].valid <= ctrl[t].valid;
      end
      if (adv) begin
        ctrl[t+1].mode <= ctrl[t].mode;
        ctrl[t+1].deg  <= ctrl[t].deg;
        ctrl[t+1].half <= ctrl[t].half;
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      c[l] = sat(q[l], qn[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (adv) begin
      out.valid <= ctrl[DIV_STAGES].valid;
    end
    if (adv) begin
      out.degenerate <= ctrl[DIV_STAGES].deg;
      if (ctrl[DIV_STAGES].deg) begin
        out.quat_w <= '0;
        out.quat_x <= '0;
        out.quat_y <= '0;
        out.quat_z <= '0;
      end else begin
        case (ctrl[DIV_STAGES].mode)
          MODE_TRACE: begin
            out.quat_w <= $signed(ctrl[DIV_STAGES].half);
            out.quat_x <= c[0];
            out.quat_y <= c[1];
            out.quat_z <= c[2];
          end
          MODE_X: begin
            out.quat_x <= $signed(ctrl[DIV_STAGES].half);
            out.quat_w <= c[0];
            out.quat_y <= c[1];
            out.quat_z <= c[2];
          end
          MODE_Y: begin
            out.quat_y <= $signed(ctrl[DIV_STAGES].half);
            out.quat_w <= c[0];
            out.quat_z <= c[1];
            out.quat_x <= c[2];
          end
          default: begin
            out.quat_z <= $signed(ctrl[DIV_STAGES].half);
            out.quat_w <= c[0];
            out.quat_x <= c[1];
            out.quat_y <= c[2];
          end
        endcase
      end
    end
  end

endmodule
